### src/dpya_pkg.sv
package dpya_pkg;

    localparam int DATA_W        = 48;
    localparam int SIN_W         = 17;
    localparam int NCOMP         = 6;
    localparam int NUM_NODES_DEF = 32;

    localparam logic [SIN_W-1:0] ONE_Q16 = 17'd65536;

    typedef logic signed [DATA_W-1:0] stress_t;
    typedef logic [SIN_W-1:0]         q16_t;

    // one node as it travels from the front to the back
    typedef struct packed {
        stress_t [NCOMP-1:0] s;    // xx, yy, zz, xy, yz, xz
        stress_t             coh;  // element cohesion term, latched at first node
        q16_t                sin;  // element sine term, latched and saturated
        logic                last; // closes the element
    } node_t;

    function automatic q16_t sat_one(input q16_t v);
        return (v > ONE_Q16) ? ONE_Q16 : v;
    endfunction

endpackage

### src/dpya_queue.sv
module dpya_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    output logic             valid,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == 2'd2);
    assign valid   = (count_reg != 2'd0);
    assign rd_data = slot_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_rd)
                rd_ptr_reg <= !rd_ptr_reg;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 2'd1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

### src/dpya_front.sv
module dpya_front #(
    parameter int NUM_NODES = 32,
    localparam int AW = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  dpya_pkg::node_t in_node,
    output logic            q_valid,
    input  logic            q_pop,
    output dpya_pkg::node_t q_node,
    output logic [AW-1:0]   q_idx
);
    import dpya_pkg::*;

    logic [AW-1:0] cnt_reg;
    stress_t       coh_reg;
    q16_t          sin_reg;
    logic          accept;
    logic          first;
    logic          is_last;
    node_t         push_node;

    assign accept  = push && !full;
    assign first   = (cnt_reg == '0);
    // an element that runs to the node limit is closed at its last slot
    assign is_last = in_node.last || (cnt_reg == AW'(NUM_NODES - 1));

    always_comb
    begin
        push_node      = in_node;
        push_node.coh  = first ? in_node.coh : coh_reg;
        push_node.sin  = first ? sat_one(in_node.sin) : sin_reg;
        push_node.last = is_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            coh_reg <= '0;
            sin_reg <= '0;
        end
        else if (accept)
        begin
            cnt_reg <= is_last ? '0 : cnt_reg + AW'(1);
            if (first)
            begin
                coh_reg <= in_node.coh;
                sin_reg <= sat_one(in_node.sin);
            end
        end
    end

    dpya_queue #(
        .WIDTH ($bits(node_t) + AW)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data ({cnt_reg, push_node}),
        .full    (full),
        .valid   (q_valid),
        .rd_en   (q_pop),
        .rd_data ({q_idx, q_node})
    );

endmodule

### src/dpya_back.sv
module dpya_back #(
    parameter int NUM_NODES = 32,
    localparam int AW = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_pop,
    input  dpya_pkg::node_t     q_node,
    input  logic [AW-1:0]       q_idx,
    input  dpya_pkg::q16_t      relax,
    output logic                empty,
    input  logic                pop,
    output dpya_pkg::stress_t   out_xx,
    output dpya_pkg::stress_t   out_yy,
    output dpya_pkg::stress_t   out_zz,
    output dpya_pkg::stress_t   out_xy,
    output dpya_pkg::stress_t   out_yz,
    output dpya_pkg::stress_t   out_xz,
    output logic                element_adjusted,
    output logic                last_of_element
);
    import dpya_pkg::*;

    localparam int ROW_W = NCOMP * DATA_W;
    // ceil(2^51 / 3); exact quotient for dividends below 2^50
    localparam logic [63:0] RECIP3 = 64'h0002_AAAA_AAAA_AAAB;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV3, S_DEV, S_SQ, S_SQRT, S_LIM, S_RATIO, S_FACT,
        S_SCALE, S_WRITE, S_EMIT_RD, S_EMIT_LD
    } state_t;

    state_t          state_reg;
    logic [5:0]      step_reg;
    logic [2:0]      comp_reg;
    logic [1:0]      chunk_reg;
    logic [AW-1:0]   k_reg;
    logic [AW-1:0]   last_idx_reg;
    logic            any_yield_reg;
    logic            out_valid_reg;

    node_t           node_reg;
    logic [AW-1:0]   idx_reg;
    logic [49:0]     div_a_reg;
    logic            sum_neg_reg;
    logic [48:0]     mean_reg;
    logic [48:0]     dmag_reg [NCOMP];
    logic            dpos_reg [NCOMP];
    logic [99:0]     acc_reg;
    logic [49:0]     root_reg;
    logic [50:0]     srem_reg;
    logic [48:0]     lim_reg;
    logic [15:0]     ratio_reg;
    logic [50:0]     rrem_reg;
    logic [16:0]     fm_reg;
    stress_t         scaled_reg [NCOMP];
    logic [ROW_W-1:0] mem_orig [NUM_NODES];
    logic [ROW_W-1:0] mem_scl [NUM_NODES];
    logic [ROW_W-1:0] rd_orig_reg;
    logic [ROW_W-1:0] rd_scl_reg;
    stress_t         out_reg [NCOMP];
    logic            out_adj_reg;
    logic            out_last_reg;

    // combinational datapath
    logic signed [49:0] sum_c;
    logic [49:0]        abs_sum_c;
    logic [15:0]        dv3_b_c;
    logic [65:0]        dv3_prod_c;
    logic [99:0]        dv3_sum_c;
    logic [48:0]        dmag_c [NCOMP];
    logic               dpos_c [NCOMP];
    logic [63:0]        sq_a64_c;
    logic [15:0]        sq_b_c;
    logic [64:0]        sq_prod_c;
    logic [5:0]         sq_sh_c;
    logic [99:0]        acc_sum_c;
    logic [52:0]        sq_pre_c;
    logic [52:0]        sq_trial_c;
    logic               sq_ge_c;
    logic [47:0]        mmag_c;
    logic [64:0]        mp_c;
    logic [48:0]        pm_c;
    logic signed [50:0] lim_s_c;
    logic [48:0]        lim_c;
    logic [50:0]        rr_sh_c;
    logic               rr_ge_c;
    q16_t               relax_sat_c;
    logic [33:0]        fp_c;
    logic [65:0]        sc_prod_c;
    logic [49:0]        sc_r_c;
    logic signed [50:0] sc_v_c;
    stress_t            sc_sat_c;
    logic [ROW_W-1:0]   scl_row_c;
    logic [ROW_W-1:0]   rd_row_c;
    logic               out_free;
    logic               elem_done;

    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign out_free  = !out_valid_reg || pop;
    assign elem_done = (state_reg == S_EMIT_LD) && out_free && (k_reg == last_idx_reg);

    always_comb
    begin
        sum_c = $signed({{2{q_node.s[0][DATA_W-1]}}, q_node.s[0]})
              + $signed({{2{q_node.s[1][DATA_W-1]}}, q_node.s[1]})
              + $signed({{2{q_node.s[2][DATA_W-1]}}, q_node.s[2]});
        abs_sum_c = sum_c[49] ? 50'(-sum_c) : 50'(sum_c);

        // divide by three: multiply by the reciprocal, one 16-bit slice a step
        dv3_b_c    = RECIP3[step_reg[1:0]*16 +: 16];
        dv3_prod_c = div_a_reg * dv3_b_c;
        dv3_sum_c  = acc_reg + (100'(dv3_prod_c) << {step_reg[1:0], 4'd0});

        for (int i = 0; i < NCOMP; i++)
        begin
            logic signed [49:0] dv;
            dv = $signed({{2{node_reg.s[i][DATA_W-1]}}, node_reg.s[i]});
            if (i < 3)
                dv = dv - $signed({mean_reg[48], mean_reg});
            dpos_c[i] = !dv[49];
            dmag_c[i] = dv[49] ? 49'(-dv) : dv[48:0];
        end

        // squares in 16-bit slices of the multiplier; shear terms count twice
        sq_a64_c  = {15'd0, dmag_reg[comp_reg]};
        sq_b_c    = sq_a64_c[chunk_reg*16 +: 16];
        sq_prod_c = dmag_reg[comp_reg] * sq_b_c;
        sq_sh_c   = {chunk_reg, 4'd0} + ((comp_reg >= 3'd3) ? 6'd1 : 6'd0);
        acc_sum_c = acc_reg + (100'(sq_prod_c) << sq_sh_c);

        // integer square root, two radicand bits a step
        sq_pre_c   = {srem_reg, acc_reg[99:98]};
        sq_trial_c = {1'b0, root_reg, 2'b01};
        sq_ge_c    = (sq_pre_c >= sq_trial_c);

        mmag_c  = mean_reg[48] ? 48'(-mean_reg) : mean_reg[47:0];
        mp_c    = mmag_c * node_reg.sin;
        pm_c    = mean_reg[48] ? 49'((mp_c + 65'd65535) >> 16) : 49'(mp_c >> 16);
        lim_s_c = $signed({{3{node_reg.coh[DATA_W-1]}}, node_reg.coh})
                + (mean_reg[48] ? $signed({2'b00, pm_c}) : -$signed({2'b00, pm_c}));
        lim_c   = lim_s_c[50] ? '0 : lim_s_c[48:0];

        rr_sh_c = {rrem_reg[49:0], 1'b0};
        rr_ge_c = (rr_sh_c >= {1'b0, root_reg});

        relax_sat_c = sat_one(relax);
        fp_c        = (ONE_Q16 - {1'b0, ratio_reg}) * relax_sat_c;

        sc_prod_c = dmag_reg[comp_reg] * fm_reg;
        sc_r_c    = sc_prod_c[65:16];
        sc_v_c    = (fm_reg != '0 && dpos_reg[comp_reg]) ? -$signed({1'b0, sc_r_c})
                                                         : $signed({1'b0, sc_r_c});
        if (sc_v_c > 51'sh7FFF_FFFF_FFFF)
            sc_sat_c = 48'sh7FFF_FFFF_FFFF;
        else if (sc_v_c < -51'sh8000_0000_0000)
            sc_sat_c = 48'sh8000_0000_0000;
        else
            sc_sat_c = sc_v_c[47:0];

        for (int i = 0; i < NCOMP; i++)
            scl_row_c[i*DATA_W +: DATA_W] = scaled_reg[i];
        rd_row_c = any_yield_reg ? rd_scl_reg : rd_orig_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            comp_reg      <= '0;
            chunk_reg     <= '0;
            k_reg         <= '0;
            last_idx_reg  <= '0;
            any_yield_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop && out_valid_reg && state_reg != S_EMIT_LD)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    step_reg <= '0;
                    if (q_valid)
                        state_reg <= S_DIV3;
                end
                S_DIV3:
                begin
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'd3)
                        state_reg <= S_DEV;
                end
                S_DEV:
                begin
                    comp_reg  <= '0;
                    chunk_reg <= '0;
                    state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    chunk_reg <= chunk_reg + 2'd1;
                    if (chunk_reg == 2'd3)
                    begin
                        comp_reg <= comp_reg + 3'd1;
                        if (comp_reg == 3'(NCOMP - 1))
                        begin
                            step_reg  <= '0;
                            state_reg <= S_SQRT;
                        end
                    end
                end
                S_SQRT:
                begin
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'd49)
                        state_reg <= S_LIM;
                end
                S_LIM:
                begin
                    step_reg  <= '0;
                    comp_reg  <= '0;
                    state_reg <= ({1'b0, lim_c} < root_reg) ? S_RATIO : S_SCALE;
                end
                S_RATIO:
                begin
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'd15)
                        state_reg <= S_FACT;
                end
                S_FACT:
                begin
                    any_yield_reg <= 1'b1;
                    state_reg     <= S_SCALE;
                end
                S_SCALE:
                begin
                    comp_reg <= comp_reg + 3'd1;
                    if (comp_reg == 3'(NCOMP - 1))
                        state_reg <= S_WRITE;
                end
                S_WRITE:
                begin
                    k_reg        <= '0;
                    last_idx_reg <= idx_reg;
                    state_reg    <= node_reg.last ? S_EMIT_RD : S_IDLE;
                end
                S_EMIT_RD:
                    state_reg <= S_EMIT_LD;
                S_EMIT_LD:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (elem_done)
                        begin
                            any_yield_reg <= 1'b0;
                            state_reg     <= S_IDLE;
                        end
                        else
                        begin
                            k_reg     <= k_reg + AW'(1);
                            state_reg <= S_EMIT_RD;
                        end
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    node_reg    <= q_node;
                    idx_reg     <= q_idx;
                    div_a_reg   <= abs_sum_c;
                    sum_neg_reg <= sum_c[49];
                    acc_reg     <= '0;
                end
            end
            S_DIV3:
            begin
                acc_reg <= dv3_sum_c;
                if (step_reg == 6'd3)
                    mean_reg <= sum_neg_reg ? 49'(-dv3_sum_c[99:51]) : dv3_sum_c[99:51];
            end
            S_DEV:
            begin
                for (int i = 0; i < NCOMP; i++)
                begin
                    dmag_reg[i] <= dmag_c[i];
                    dpos_reg[i] <= dpos_c[i];
                end
                acc_reg  <= '0;
                root_reg <= '0;
                srem_reg <= '0;
            end
            S_SQ:
            begin
                if (chunk_reg == 2'd3 && comp_reg == 3'(NCOMP - 1))
                    acc_reg <= acc_sum_c >> 1;
                else
                    acc_reg <= acc_sum_c;
            end
            S_SQRT:
            begin
                srem_reg <= sq_ge_c ? 51'(sq_pre_c - sq_trial_c) : sq_pre_c[50:0];
                root_reg <= {root_reg[48:0], sq_ge_c};
                acc_reg  <= {acc_reg[97:0], 2'b00};
            end
            S_LIM:
            begin
                lim_reg   <= lim_c;
                rrem_reg  <= {2'b00, lim_c};
                ratio_reg <= '0;
                fm_reg    <= '0;
            end
            S_RATIO:
            begin
                rrem_reg  <= rr_ge_c ? (rr_sh_c - {1'b0, root_reg}) : rr_sh_c;
                ratio_reg <= {ratio_reg[14:0], rr_ge_c};
            end
            S_FACT:
                fm_reg <= fp_c[32:16];
            S_SCALE:
                scaled_reg[comp_reg] <= sc_sat_c;
            S_WRITE:
            begin
                mem_orig[idx_reg] <= node_reg.s;
                mem_scl[idx_reg]  <= scl_row_c;
            end
            S_EMIT_RD:
            begin
                rd_orig_reg <= mem_orig[k_reg];
                rd_scl_reg  <= mem_scl[k_reg];
            end
            S_EMIT_LD:
            begin
                if (out_free)
                begin
                    for (int i = 0; i < NCOMP; i++)
                        out_reg[i] <= rd_row_c[i*DATA_W +: DATA_W];
                    out_adj_reg  <= any_yield_reg;
                    out_last_reg <= (k_reg == last_idx_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign empty            = !out_valid_reg;
    assign out_xx           = out_reg[0];
    assign out_yy           = out_reg[1];
    assign out_zz           = out_reg[2];
    assign out_xy           = out_reg[3];
    assign out_yz           = out_reg[4];
    assign out_xz           = out_reg[5];
    assign element_adjusted = out_adj_reg;
    assign last_of_element  = out_last_reg;

`ifndef ASSERT_OFF
    // a result only appears out of the load step of the flush
    a_load_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EMIT_LD))
        else $error("result appeared outside the flush");

    // a factor is only formed for a node whose tau is above its limit
    a_yield_only: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FACT) |-> ({1'b0, lim_reg} < root_reg))
        else $error("factor formed for a node below yield");

    // the element flag cannot change in the middle of a flush
    a_flag_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT_RD) |=> $stable(any_yield_reg))
        else $error("yield flag changed during flush");

    // no node is taken from the queue while the flush is running
    a_no_pop_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT_RD || state_reg == S_EMIT_LD) |-> !q_pop)
        else $error("node taken during flush");
`endif

endmodule

### src/drucker_prager_yield_adjust.sv
// Drucker-Prager yield adjustment of one element's nodal stresses (Q32.16).
// Nodes are pushed one per beat while full is low; a front stage latches the
// element's cohesion and friction terms from the first node and hands nodes
// through a two-deep queue to the back stage, which works one node at a time:
// a divide by three as a reciprocal multiply in 16-bit slices, six full-width
// squares in 16-bit slices, a bit-serial square root, the limit, and on yield
// a bit-serial ratio divide and the factor, then the scaling of each of the six
// components and a row write; most of a node's time goes to the square root
// and the squares. After the last node (or NUM_NODES nodes) the element is
// flushed from two row memories, each result read and then loaded once the
// output is free. relax_factor may be written only while the block is idle;
// values above 1.0 act as 1.0.
module drucker_prager_yield_adjust #(
    parameter int NUM_NODES = dpya_pkg::NUM_NODES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  dpya_pkg::stress_t stress_xx,
    input  dpya_pkg::stress_t stress_yy,
    input  dpya_pkg::stress_t stress_zz,
    input  dpya_pkg::stress_t stress_xy,
    input  dpya_pkg::stress_t stress_yz,
    input  dpya_pkg::stress_t stress_xz,
    input  dpya_pkg::stress_t cohesion_cos_term,
    input  dpya_pkg::q16_t    sin_friction,
    input  logic              last_node,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  dpya_pkg::q16_t    relax_factor,
    output logic              empty,
    input  logic              pop,
    output dpya_pkg::stress_t out_xx,
    output dpya_pkg::stress_t out_yy,
    output dpya_pkg::stress_t out_zz,
    output dpya_pkg::stress_t out_xy,
    output dpya_pkg::stress_t out_yz,
    output dpya_pkg::stress_t out_xz,
    output logic              element_adjusted,
    output logic              last_of_element
);
    import dpya_pkg::*;

    localparam int AW = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;

    q16_t          relax_reg;
    node_t         in_node;
    node_t         q_node;
    logic [AW-1:0] q_idx;
    logic          q_valid;
    logic          q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            relax_reg <= ONE_Q16;
        else if (cfg_valid && cfg_ready)
            relax_reg <= relax_factor;
    end

    always_comb
    begin
        in_node.s[0] = stress_xx;
        in_node.s[1] = stress_yy;
        in_node.s[2] = stress_zz;
        in_node.s[3] = stress_xy;
        in_node.s[4] = stress_yz;
        in_node.s[5] = stress_xz;
        in_node.coh  = cohesion_cos_term;
        in_node.sin  = sin_friction;
        in_node.last = last_node;
    end

    dpya_front #(
        .NUM_NODES (NUM_NODES)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .in_node (in_node),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_node  (q_node),
        .q_idx   (q_idx)
    );

    dpya_back #(
        .NUM_NODES (NUM_NODES)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (q_valid),
        .q_pop            (q_pop),
        .q_node           (q_node),
        .q_idx            (q_idx),
        .relax            (relax_reg),
        .empty            (empty),
        .pop              (pop),
        .out_xx           (out_xx),
        .out_yy           (out_yy),
        .out_zz           (out_zz),
        .out_xy           (out_xy),
        .out_yz           (out_yz),
        .out_xz           (out_xz),
        .element_adjusted (element_adjusted),
        .last_of_element  (last_of_element)
    );

endmodule
